@@ rtl/assert_macros.svh @@
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked during reset
`define DPS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dps assertion failed");

// next-cycle implication, masked during reset
`define DPS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dps assertion failed");

// next-cycle implication, checked through reset as well
`define DPS_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("dps assertion failed");

`endif

@@ rtl/dps_pkg.sv @@
// shared types and constants of the position depth summary block
`default_nettype none
package dps_pkg;
   localparam int MAX_SAMPLES_DEF = 1024;
   localparam int DEPTH_BITS_DEF = 24;
   localparam int NUM_THRESH = 9;
   localparam int CSR_W = 11;
   localparam int FRAC_W = 17;
   localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

   localparam logic [6:0] THRESH [NUM_THRESH] = '{7'd1, 7'd5, 7'd10, 7'd15, 7'd20,
                                                 7'd25, 7'd30, 7'd50, 7'd100};

   typedef struct packed {
      logic [31:0] position;
      logic [23:0] depth;
      logic        last_in_group;
   } req_type;

   typedef struct packed {
      logic [31:0]       out_position;
      logic [31:0]       mean_depth;
      logic [24:0]       median_twice;
      logic [FRAC_W-1:0] frac_ge_1;
      logic [FRAC_W-1:0] frac_ge_5;
      logic [FRAC_W-1:0] frac_ge_10;
      logic [FRAC_W-1:0] frac_ge_15;
      logic [FRAC_W-1:0] frac_ge_20;
      logic [FRAC_W-1:0] frac_ge_25;
      logic [FRAC_W-1:0] frac_ge_30;
      logic [FRAC_W-1:0] frac_ge_50;
      logic [FRAC_W-1:0] frac_ge_100;
   } rsp_type;

   // one slot of the sorting chain
   typedef struct packed {
      logic        valid;
      logic [23:0] value;
   } cell_bus_type;
endpackage
`default_nettype wire

@@ rtl/dps_chan_if.sv @@
// valid/ready channel carrying one payload
`default_nettype none
interface dps_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/dps_cell.sv @@
// one cell of the insertion sorting chain
`default_nettype none
module dps_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  clear,
   input  wire logic                  shift,
   input  wire dps_pkg::cell_bus_type pass_in,
   input  wire dps_pkg::cell_bus_type next_hold,
   output dps_pkg::cell_bus_type      hold_out,
   output dps_pkg::cell_bus_type      pass_out
);
   import dps_pkg::*;

   cell_bus_type hold_ff, hold_in;
   cell_bus_type pass_ff, pass_in_nxt;

   // clear empties the cell, shift takes the next cell's value; else keep the smaller value, hand the larger one on
   always_comb begin
      hold_in = hold_ff;
      pass_in_nxt = '0;
      if (clear) begin
         hold_in.valid = 1'b0;
      end else if (shift) begin
         hold_in = next_hold;
      end else if (pass_in.valid) begin
         if (!hold_ff.valid) begin
            hold_in = pass_in;
         end else if (pass_in.value < hold_ff.value) begin
            hold_in = pass_in;
            pass_in_nxt = hold_ff;
         end else begin
            pass_in_nxt = pass_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff.valid <= 1'b0;
         pass_ff.valid <= 1'b0;
      end else begin
         hold_ff.valid <= hold_in.valid;
         pass_ff.valid <= pass_in_nxt.valid;
      end
      hold_ff.value <= hold_in.value;
      pass_ff.value <= pass_in_nxt.value;
   end

   assign hold_out = hold_ff;
   assign pass_out = pass_ff;
endmodule
`default_nettype wire

@@ rtl/dps_divider.sv @@
// restoring divider, one quotient bit per cycle
`default_nettype none
module dps_divider #(
   parameter int DW = 43,
   parameter int VW = 11
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [VW-1:0] divisor,
   output logic               done,
   output logic [DW-1:0]      quotient
);
   localparam int CNT_W = $clog2(DW);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [VW-1:0]    rem_ff;
   logic [DW-1:0]    quo_ff;
   logic [VW-1:0]    dsr_ff;
   logic [VW:0]      trial;
   logic [VW:0]      diff;
   logic             ge;

   // trial subtraction of one step
   always_comb begin
      trial = {rem_ff, quo_ff[DW-1]};
      diff = trial - {1'b0, dsr_ff};
      ge = trial >= {1'b0, dsr_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == CNT_W'(DW - 1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DW - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[VW-1:0] : trial[VW-1:0];
         quo_ff <= {quo_ff[DW-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

@@ rtl/position_depth_summary.sv @@
// position depth summary: per-position mean, median and threshold shares
// after the closing request the sorting chain settles, shifts down to the median and captures it, while
//   ten serial divisions (DW = 32 + width of the group count) form the mean and the threshold shares;
//   the summary is offered once both are done
// throughput: one request per cycle within a group, then the block is busy until the result
// reset: synchronous, active high; clears counters, sorting chain valid bits and sample_count to 1
`default_nettype none
module position_depth_summary #(
   parameter int MAX_SAMPLES = dps_pkg::MAX_SAMPLES_DEF,
   parameter int DEPTH_BITS = dps_pkg::DEPTH_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   dps_chan_if.sink   req_chan,
   dps_chan_if.source rsp_chan,
   dps_chan_if.sink   csr_chan
);
   import dps_pkg::*;

   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int SW = 24 + CW;
   localparam int DW = SW + 8;
   localparam int VW = (CW > CSR_W) ? CW : CSR_W;
   localparam logic [23:0] DMASK =
      (DEPTH_BITS >= 24) ? {24{1'b1}} : 24'((64'd1 << DEPTH_BITS) - 64'd1);
   localparam logic [3:0] LAST_JOB = 4'(NUM_THRESH);

   typedef enum logic [3:0] {
      S_FILL   = 4'b0001,
      S_SETTLE = 4'b0010,
      S_SHIFT  = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [CSR_W-1:0]  sample_count_ff;
   logic [CW-1:0]     count_ff;
   logic [SW-1:0]     sum_ff;
   logic [CW-1:0]     tc_ff [NUM_THRESH];
   logic [31:0]       pos_ff;
   logic [CW-1:0]     cnt_ff;
   logic [24:0]       median_ff;
   logic [3:0]        job_ff;
   logic              div_go_ff;
   logic              div_all_ff;
   logic [31:0]       mean_ff;
   logic [FRAC_W-1:0] frac_ff [NUM_THRESH];
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;

   logic          accept;
   logic          room;
   logic [23:0]   depth_eff;
   logic [CW-1:0] target;
   logic          shift;
   logic          capture;
   logic          load_out;
   logic          div_done;
   logic [DW-1:0] div_quo;
   logic [DW-1:0] div_dividend;
   logic [VW-1:0] div_divisor;
   logic [CSR_W-1:0] sc_eff;

   cell_bus_type hold [MAX_SAMPLES];
   cell_bus_type pass [MAX_SAMPLES];
   cell_bus_type insert;

   assign req_chan.ready = (state_ff == S_FILL);
   assign csr_chan.ready = 1'b1;
   assign accept = req_chan.valid && req_chan.ready;
   assign room = count_ff < CW'(MAX_SAMPLES);
   assign depth_eff = req_chan.payload.depth & DMASK;
   assign target = (count_ff - 1'b1) >> 1;
   assign shift = (state_ff == S_SHIFT) && (cnt_ff != target);
   assign capture = (state_ff == S_SHIFT) && (cnt_ff == target);
   assign load_out = (state_ff == S_FINISH) && div_all_ff && (!rsp_valid_ff || rsp_chan.ready);

   // new depth enters the head of the chain
   always_comb begin
      insert.valid = accept && room;
      insert.value = depth_eff;
   end

   // sorting chain, smallest value at the head
   for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
      cell_bus_type pin, nxt;
      assign pin = (i == 0) ? insert : pass[(i == 0) ? 0 : i - 1];
      assign nxt = (i == MAX_SAMPLES - 1) ? cell_bus_type'('0)
                                          : hold[(i == MAX_SAMPLES - 1) ? i : i + 1];
      dps_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .clear     (capture),
         .shift     (shift),
         .pass_in   (pin),
         .next_hold (nxt),
         .hold_out  (hold[i]),
         .pass_out  (pass[i])
      );
   end

   // operands of the current division
   always_comb begin
      sc_eff = (sample_count_ff == '0) ? CSR_W'(1) : sample_count_ff;
      if (job_ff == '0) begin
         div_dividend = {sum_ff, 8'h00};
         div_divisor = VW'(count_ff);
      end else begin
         div_dividend = DW'({tc_ff[job_ff - 1'b1], 16'h0000});
         div_divisor = VW'(sc_eff);
      end
   end

   dps_divider #(.DW(DW), .VW(VW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_FILL: begin
            if (accept && req_chan.payload.last_in_group) state_in = S_SETTLE;
         end
         S_SETTLE: begin
            if (cnt_ff == count_ff) state_in = S_SHIFT;
         end
         S_SHIFT: begin
            if (capture) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (load_out) state_in = S_FILL;
         end
         default: state_in = S_FILL;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_FILL;
         sample_count_ff <= CSR_W'(1);
         count_ff <= '0;
         sum_ff <= '0;
         pos_ff <= '0;
         cnt_ff <= '0;
         job_ff <= '0;
         div_go_ff <= 1'b0;
         div_all_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_THRESH; k++) tc_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         div_go_ff <= (accept && req_chan.payload.last_in_group) ||
                      (div_done && (job_ff != LAST_JOB));
         if (csr_chan.valid) sample_count_ff <= csr_chan.payload;
         // group accumulation
         if (accept) begin
            if (count_ff == '0) pos_ff <= req_chan.payload.position;
            if (room) begin
               count_ff <= count_ff + 1'b1;
               sum_ff <= sum_ff + SW'(depth_eff);
               for (int k = 0; k < NUM_THRESH; k++) begin
                  if (depth_eff >= 24'(THRESH[k])) tc_ff[k] <= tc_ff[k] + 1'b1;
               end
            end
            if (req_chan.payload.last_in_group) begin
               cnt_ff <= '0;
               job_ff <= '0;
               div_all_ff <= 1'b0;
            end
         end
         // settle and shift counting
         if (state_ff == S_SETTLE) begin
            cnt_ff <= (cnt_ff == count_ff) ? '0 : cnt_ff + 1'b1;
         end
         if (shift) cnt_ff <= cnt_ff + 1'b1;
         // division sequence
         if (div_done) begin
            if (job_ff == LAST_JOB) begin
               div_all_ff <= 1'b1;
            end else begin
               job_ff <= job_ff + 1'b1;
            end
         end
         // result hand-off
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
            count_ff <= '0;
            sum_ff <= '0;
            pos_ff <= '0;
            for (int k = 0; k < NUM_THRESH; k++) tc_ff[k] <= '0;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (capture) begin
         median_ff <= 25'(hold[0].value)
                    + 25'(count_ff[0] ? hold[0].value : hold[1].value);
      end
      if (div_done) begin
         if (job_ff == '0) begin
            mean_ff <= (div_quo > DW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : div_quo[31:0];
         end else begin
            frac_ff[job_ff - 1'b1] <= (div_quo > DW'(FRAC_ONE)) ? FRAC_ONE
                                                                : div_quo[FRAC_W-1:0];
         end
      end
      if (load_out) begin
         rsp_ff.out_position <= pos_ff;
         rsp_ff.mean_depth <= mean_ff;
         rsp_ff.median_twice <= median_ff;
         rsp_ff.frac_ge_1 <= frac_ff[0];
         rsp_ff.frac_ge_5 <= frac_ff[1];
         rsp_ff.frac_ge_10 <= frac_ff[2];
         rsp_ff.frac_ge_15 <= frac_ff[3];
         rsp_ff.frac_ge_20 <= frac_ff[4];
         rsp_ff.frac_ge_25 <= frac_ff[5];
         rsp_ff.frac_ge_30 <= frac_ff[6];
         rsp_ff.frac_ge_50 <= frac_ff[7];
         rsp_ff.frac_ge_100 <= frac_ff[8];
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;
endmodule
`default_nettype wire

@@ rtl/dps_checker.sv @@
// port-level checker for the position depth summary, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module dps_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_last,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [16:0] rsp_frac_1,
   input wire logic [16:0] rsp_frac_100
);
   // a closing request makes the block busy
   `DPS_ASSERT_NXT(a_busy_after_last, clock, reset, req_valid && req_ready && req_last, !req_ready)
   // no result straight out of reset
   `DPS_ASSERT_NXT_ALL(a_quiet_after_reset, clock, reset, !rsp_valid)
   // the share at 1 never exceeds one, the share at 100 never exceeds the share at 1
   `DPS_ASSERT_IMP(a_frac_order, clock, reset, rsp_valid,
      rsp_frac_1 <= 17'h10000 && rsp_frac_100 <= rsp_frac_1)
   // a waiting result stays offered
   `DPS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
endmodule

bind position_depth_summary dps_checker u_dps_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .req_last     (req_chan.payload.last_in_group),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_frac_1   (rsp_chan.payload.frac_ge_1),
   .rsp_frac_100 (rsp_chan.payload.frac_ge_100)
);
`default_nettype wire
